>>> rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants for the beat repeat stutter block
// Register indexes, Q15 constants and the control structs that pass between
// the configuration, controller and datapath modules.
// ----------------------------------------------------------------------------
package brs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANCE           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY            = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIX              = 3'd5;

	// Q15 unity, one bit wider than a sample
	localparam logic [16:0] Q15_ONE = 17'd32768;

	localparam int POS_W = 15;

	// Register file after clamping; chance and slice_length stay raw (the
	// clamp of slice_length depends on the store depth)
	typedef struct packed {
		logic [19:0] trigger_interval;
		logic [15:0] slice_length;
		logic [16:0] chance;
		logic [6:0]  repeat_count;
		logic [15:0] decay;
		logic [15:0] mix;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic write;
		logic read;
		logic wet;
		logic mix;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

>>> rtl/beat_repeat_stutter.sv
// ----------------------------------------------------------------------------
// beat_repeat_stutter: stereo beat-repeat stutter effect
// Stores every frame in a circular store, replays the latest slice on a
// random trigger with per-repeat gain decay, and mixes dry and wet in Q15.
//
//   port group   dir  beat contents
//   s_*          in   one input frame: left, right, random draw
//   m_*          out  one mixed frame and its replay flag
//   cfg_*        in   one register write: index and value
//
// A frame passes from acceptance to its result entering the output register
// through store write, store read, wet scaling, two mix multiplies per
// channel, then round and saturate into the register. The single store port
// and the multiplier stages set this sequence; the next frame is taken the
// cycle after the result is loaded, so one frame ends before the next begins.
// Reset needs no clearing pass: a fill mark makes unwritten entries read zero.
// A result that is not taken holds in the output register; the next frame is
// still accepted and stalls only at its final load.
// ----------------------------------------------------------------------------
module beat_repeat_stutter #(
	parameter int STORE_DEPTH = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,   // in_left, in_right, random_draw
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // out_left, out_right
	output logic                            m_tuser,   // repeating
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	brs_pkg::cfg_t cfg;
	brs_pkg::cmd_t cmd;
	brs_pkg::sts_t sts;

	brs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	brs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brs_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_flag  (m_tuser)
	);

endmodule

>>> rtl/brs_cfg.sv
// ----------------------------------------------------------------------------
// brs_cfg: configuration register file
// Takes register writes; clamps trigger interval, repeat count, decay and mix to their usable range.
// ----------------------------------------------------------------------------
module brs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [brs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output brs_pkg::cfg_t                    cfg
);

	brs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_interval <= 20'd24000;
			cfg_q.slice_length     <= 16'd6000;
			cfg_q.chance           <= 17'd32768;
			cfg_q.repeat_count     <= 7'd4;
			cfg_q.decay            <= 16'd0;
			cfg_q.mix              <= 16'd32768;
		end else if (cfg_valid) begin
			case (cfg_index)
				brs_pkg::REG_TRIGGER_INTERVAL: begin
					// zero interval acts as one
					cfg_q.trigger_interval <= (cfg_data == '0) ? 20'd1 : cfg_data;
				end
				brs_pkg::REG_SLICE_LENGTH: begin
					cfg_q.slice_length <= cfg_data[15:0];
				end
				brs_pkg::REG_CHANCE: begin
					cfg_q.chance <= cfg_data[16:0];
				end
				brs_pkg::REG_REPEAT_COUNT: begin
					cfg_q.repeat_count <= (cfg_data[6:0] == '0) ? 7'd1 : cfg_data[6:0];
				end
				brs_pkg::REG_DECAY: begin
					cfg_q.decay <= ({1'b0, cfg_data[15:0]} > brs_pkg::Q15_ONE) ?
						16'd32768 : cfg_data[15:0];
				end
				brs_pkg::REG_MIX: begin
					cfg_q.mix <= ({1'b0, cfg_data[15:0]} > brs_pkg::Q15_ONE) ?
						16'd32768 : cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/brs_ctrl.sv
// ----------------------------------------------------------------------------
// brs_ctrl: frame sequencer
// Steps one frame through write, read, wet scaling, mix and output load.
// ----------------------------------------------------------------------------
module brs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  brs_pkg::sts_t   sts,
	output brs_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_WET,
		S_MIX,
		S_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.write  = (state_q == S_WRITE);
		cmd.read   = (state_q == S_READ);
		cmd.wet    = (state_q == S_WET);
		cmd.mix    = (state_q == S_MIX);
		cmd.load   = (state_q == S_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_WRITE;
				end
				S_WRITE: state_q <= S_READ;
				S_READ:  state_q <= S_WET;
				S_WET:   state_q <= S_MIX;
				S_MIX:   state_q <= S_FIN;
				S_FIN: begin
					// hold until the output register can take the beat
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/brs_dp.sv
// ----------------------------------------------------------------------------
// brs_dp: stutter datapath
// Sample store, trigger and replay state, gain and dry/wet mix arithmetic,
// and the output register.
// ----------------------------------------------------------------------------
module brs_dp #(
	parameter int STORE_DEPTH = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  brs_pkg::cfg_t   cfg,
	input  brs_pkg::cmd_t   cmd,
	output brs_pkg::sts_t   sts,
	input  logic [47:0]     in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_data,
	output logic            out_flag
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int HALF = STORE_DEPTH / 2;
	localparam int XW   = ((AW > 16) ? AW : 16) + 1;

	logic [31:0] store_mem [STORE_DEPTH];

	// captured frame
	logic signed [15:0] in_left_s1, in_right_s1;
	logic [15:0]        draw_s1;

	// effect state
	logic [AW-1:0]                wp_q;
	logic                         filled_q;
	logic                         mode_q;
	logic [19:0]                  cnt_q;
	logic [AW-1:0]                start_q;
	logic [brs_pkg::POS_W-1:0]    pos_q;
	logic [6:0]                   reps_q;
	logic [15:0]                  gain_q;

	// per-frame stages
	logic               replay_s2;
	logic [AW-1:0]      addr_s2;
	logic [15:0]        gain_s2;
	logic [31:0]        word_s3;
	logic               ok_s3;
	logic signed [31:0] wet_l_s4, wet_r_s4;
	logic signed [33:0] pd_l_s5, pd_r_s5;
	logic signed [48:0] pw_l_s5, pw_r_s5;

	logic               out_valid_q;
	logic [31:0]        out_data_q;
	logic               out_flag_q;

	// next-state logic
	logic [AW-1:0]      wp_inc;
	logic [XW-1:0]      slice_x, len_x;
	logic [AW-1:0]      len_a;
	logic [AW:0]        rewind, start_sum, addr_sum;
	logic [AW-1:0]      start_n, addr_n;
	logic [15:0]        pos1;
	logic               slice_end;
	logic [19:0]        cnt1;
	logic               trig, take;
	logic [31:0]        gain_prod;
	logic [15:0]        gain_n;
	logic [6:0]         reps1;

	// wet and mix logic
	logic signed [15:0] rd_l, rd_r;
	logic signed [16:0] gain_sg;
	logic signed [32:0] rp_l, rp_r;
	logic signed [17:0] dry_wt;
	logic signed [16:0] mix_wt;

	function automatic logic [15:0] mix_round(input logic signed [33:0] pd,
			input logic signed [48:0] pw);
		logic signed [49:0] acc;
		logic signed [19:0] q;
		logic [15:0]        res;
		acc = (50'(pd) <<< 15) + 50'(pw);
		// divide by 2^30 rounding toward zero
		q = acc[49:30] + 20'((acc[49] && (acc[29:0] != '0)) ? 1 : 0);
		if (q > 20'sd32767) res = 16'h7fff;
		else if (q < -20'sd32768) res = 16'h8000;
		else res = q[15:0];
		return res;
	endfunction

	always_comb begin
		wp_inc = (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;

		slice_x = XW'(cfg.slice_length);
		if (cfg.slice_length == '0) len_x = XW'(1);
		else if (slice_x > XW'(HALF)) len_x = XW'(HALF);
		else len_x = slice_x;
		len_a = AW'(len_x);

		rewind    = (AW+1)'(STORE_DEPTH) - {1'b0, len_a};
		start_sum = {1'b0, wp_inc} + rewind;
		start_n   = (start_sum >= (AW+1)'(STORE_DEPTH)) ?
			AW'(start_sum - (AW+1)'(STORE_DEPTH)) : AW'(start_sum);

		addr_sum = {1'b0, start_q} + (AW+1)'(pos_q);
		addr_n   = (addr_sum >= (AW+1)'(STORE_DEPTH)) ?
			AW'(addr_sum - (AW+1)'(STORE_DEPTH)) : AW'(addr_sum);

		pos1      = {1'b0, pos_q} + 16'd1;
		slice_end = XW'(pos1) >= len_x;

		cnt1 = cnt_q + 20'd1;
		trig = cnt1 >= cfg.trigger_interval;
		take = {1'b0, draw_s1} < cfg.chance;

		gain_prod = 32'(gain_q) * 32'(brs_pkg::Q15_ONE - {1'b0, cfg.decay});
		gain_n    = gain_prod[30:15];
		reps1     = reps_q + 7'd1;
	end

	always_comb begin
		rd_l    = ok_s3 ? signed'(word_s3[15:0])  : '0;
		rd_r    = ok_s3 ? signed'(word_s3[31:16]) : '0;
		gain_sg = signed'({1'b0, gain_s2});
		rp_l    = rd_l * gain_sg;
		rp_r    = rd_r * gain_sg;
		dry_wt  = signed'({1'b0, brs_pkg::Q15_ONE - {1'b0, cfg.mix}});
		mix_wt  = signed'({1'b0, cfg.mix});
	end

	// store: write the frame, read the replay word in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.write) store_mem[wp_q] <= {in_right_s1, in_left_s1};
		if (cmd.read) word_s3 <= store_mem[addr_s2];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_left_s1  <= signed'(in_data[15:0]);
			in_right_s1 <= signed'(in_data[31:16]);
			draw_s1     <= in_data[47:32];
		end
		if (cmd.write) begin
			replay_s2 <= mode_q;
			gain_s2   <= gain_q;
			addr_s2   <= addr_n;
		end
		if (cmd.read) begin
			// entries past the fill mark were never written and read as zero
			ok_s3 <= filled_q || (addr_s2 < wp_q);
		end
		if (cmd.wet) begin
			wet_l_s4 <= replay_s2 ? 32'(rp_l) : {in_left_s1[15], in_left_s1, 15'b0};
			wet_r_s4 <= replay_s2 ? 32'(rp_r) : {in_right_s1[15], in_right_s1, 15'b0};
		end
		if (cmd.mix) begin
			pd_l_s5 <= in_left_s1 * dry_wt;
			pd_r_s5 <= in_right_s1 * dry_wt;
			pw_l_s5 <= wet_l_s4 * mix_wt;
			pw_r_s5 <= wet_r_s4 * mix_wt;
		end
		if (cmd.load) begin
			out_data_q <= {mix_round(pd_r_s5, pw_r_s5), mix_round(pd_l_s5, pw_l_s5)};
			out_flag_q <= replay_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= 1'b0;
			mode_q   <= 1'b0;
			cnt_q    <= '0;
			start_q  <= '0;
			pos_q    <= '0;
			reps_q   <= '0;
			gain_q   <= 16'd32768;
		end else if (cmd.write) begin
			wp_q <= wp_inc;
			if (wp_q == AW'(STORE_DEPTH - 1)) filled_q <= 1'b1;
			if (!mode_q) begin
				if (trig) begin
					cnt_q <= '0;
					if (take) begin
						mode_q  <= 1'b1;
						start_q <= start_n;
						pos_q   <= '0;
						reps_q  <= '0;
						gain_q  <= 16'd32768;
					end
				end else begin
					cnt_q <= cnt1;
				end
			end else if (slice_end) begin
				pos_q  <= '0;
				reps_q <= reps1;
				gain_q <= gain_n;
				if (reps1 >= cfg.repeat_count) mode_q <= 1'b0;
			end else begin
				pos_q <= pos1[brs_pkg::POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_flag     = out_flag_q;

endmodule

>>> test/beat_repeat_stutter_test.sv
// ----------------------------------------------------------------------------
// beat_repeat_stutter_test: self-checking bench for the stutter effect
// A short scripted run with hand-read results, then randomized register
// settings and frames with random idling on both streams. Every result beat
// is checked field by field against its hand-read value or a bit-accurate predictor.
// ----------------------------------------------------------------------------
module beat_repeat_stutter_test;

	localparam int DEPTH      = 65536;
	localparam int IDLE_LIMIT = 4000;
	localparam int FRAME_GOAL = 1050;
	localparam int SCRIPT_LEN = 44;
	localparam int IDX_W      = brs_pkg::CFG_IDX_W;
	localparam int DATA_W     = brs_pkg::CFG_DATA_W;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [15:0]        draw;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               repeating;
	} mixed_t;

	typedef enum logic {STEP_FRAME, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t        kind;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
		frame_t            frame;
		logic              known;
		mixed_t            want;
	} script_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata   = '0;   // in_left, in_right, random_draw
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;          // out_left, out_right
	logic                  m_tuser;          // repeating
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [DATA_W-1:0]     cfg_data  = '0;

	// predictor state
	logic [31:0]   store_mem [DEPTH];
	logic [15:0]   wr_ptr;
	logic [15:0]   slice_base;
	logic [14:0]   slice_pos;
	logic [6:0]    reps_done;
	logic [19:0]   trig_cnt;
	logic          replaying;
	longint        gain;
	brs_pkg::cfg_t regs;

	mixed_t mixes_due [$];
	int     mismatches  = 0;
	int     frames_sent = 0;
	int     idle_cycles = 0;
	bit     no_idle     = 1'b0;

	beat_repeat_stutter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Q15 dry/wet blend, truncated toward zero, then saturated
	function automatic logic signed [15:0] blend(longint dry, longint wet_q15, longint m);
		longint acc;
		acc = dry * (32768 - m) * 32768 + wet_q15 * m;
		acc = acc / (longint'(1) << 30);
		if (acc > 32767) acc = 32767;
		if (acc < -32768) acc = -32768;
		return acc[15:0];
	endfunction

	function automatic mixed_t stutter_step(frame_t f);
		longint      m;
		longint      len;
		longint      ival;
		longint      dec;
		longint      rc;
		longint      wet_l;
		longint      wet_r;
		logic [15:0] addr;
		logic [31:0] word;
		mixed_t      res;
		m   = (regs.mix > 16'd32768) ? 64'd32768 : 64'(regs.mix);
		len = (regs.slice_length == 16'd0) ? 64'd1 : 64'(regs.slice_length);
		if (len > DEPTH / 2) len = DEPTH / 2;
		store_mem[wr_ptr] = {f.right, f.left};
		wr_ptr = wr_ptr + 16'd1;
		res.repeating = 1'b0;
		if (!replaying) begin
			ival = (regs.trigger_interval == 20'd0) ? 64'd1 : 64'(regs.trigger_interval);
			trig_cnt = trig_cnt + 20'd1;
			if (trig_cnt >= ival) begin
				trig_cnt = '0;
				if (f.draw < regs.chance) begin
					replaying  = 1'b1;
					slice_base = wr_ptr - 16'(len);
					slice_pos  = '0;
					reps_done  = '0;
					gain       = 32768;
				end
			end
			wet_l = longint'(f.left) * 32768;
			wet_r = longint'(f.right) * 32768;
		end else begin
			addr  = slice_base + 16'(slice_pos);
			word  = store_mem[addr];
			dec   = (regs.decay > 16'd32768) ? 64'd32768 : 64'(regs.decay);
			rc    = (regs.repeat_count == 7'd0) ? 64'd1 : 64'(regs.repeat_count);
			wet_l = longint'($signed(word[15:0])) * gain;
			wet_r = longint'($signed(word[31:16])) * gain;
			res.repeating = 1'b1;
			// a position at or past the live length closes the repeat
			if (longint'(slice_pos) + 1 >= len) begin
				slice_pos = '0;
				reps_done = reps_done + 7'd1;
				gain      = (gain * (32768 - dec)) >> 15;
				if (reps_done >= rc) replaying = 1'b0;
			end else begin
				slice_pos = slice_pos + 15'd1;
			end
		end
		res.left  = blend(f.left, wet_l, m);
		res.right = blend(f.right, wet_r, m);
		return res;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic script_row_t frame_row(int l, int r, int d);
		script_row_t row;
		row             = '0;
		row.kind        = STEP_FRAME;
		row.frame.left  = 16'(l);
		row.frame.right = 16'(r);
		row.frame.draw  = 16'(d);
		return row;
	endfunction

	function automatic script_row_t known_row(int l, int r, int d, int el, int er, bit rep);
		script_row_t row;
		row                = frame_row(l, r, d);
		row.known          = 1'b1;
		row.want.left      = 16'(el);
		row.want.right     = 16'(er);
		row.want.repeating = rep;
		return row;
	endfunction

	function automatic script_row_t write_row(logic [IDX_W-1:0] idx, int v);
		script_row_t row;
		row       = '0;
		row.kind  = STEP_WRITE;
		row.index = idx;
		row.value = DATA_W'(v);
		return row;
	endfunction

	function automatic void report_miss(mixed_t want, mixed_t got, bit orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("unexpected result beat: left %0d right %0d repeating %0b",
					got.left, got.right, got.repeating);
			else
				$display("result mismatch: expected %0d %0d %0b, got %0d %0d %0b",
					want.left, want.right, want.repeating,
					got.left, got.right, got.repeating);
		end
	endfunction

	task automatic send_frame(frame_t f, bit known, mixed_t want);
		int     gap;
		mixed_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {f.draw, f.right, f.left};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = stutter_step(f);
		mixes_due.push_back(known ? want : predicted);
		frames_sent++;
	endtask

	// hold the input side until every result beat is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (mixes_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			brs_pkg::REG_TRIGGER_INTERVAL: regs.trigger_interval = val[19:0];
			brs_pkg::REG_SLICE_LENGTH:     regs.slice_length     = val[15:0];
			brs_pkg::REG_CHANCE:           regs.chance           = val[16:0];
			brs_pkg::REG_REPEAT_COUNT:     regs.repeat_count     = val[6:0];
			brs_pkg::REG_DECAY:            regs.decay            = val[15:0];
			brs_pkg::REG_MIX:              regs.mix              = val[15:0];
			default: ;
		endcase
		if (last) cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_sink
		int     stall;
		mixed_t got;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.left      = m_tdata[15:0];
			got.right     = m_tdata[31:16];
			got.repeating = m_tuser;
			if (mixes_due.size() == 0) begin
				report_miss(got, got, 1'b1);
			end else begin
				if (got !== mixes_due[0]) report_miss(mixes_due[0], got, 1'b0);
				void'(mixes_due.pop_front());
			end
		end
	end

	initial begin : stimulus
		script_row_t       script [SCRIPT_LEN];
		logic [IDX_W-1:0]  reg_order [6];
		logic [DATA_W-1:0] setting;
		logic [5:0]        mask;
		frame_t            f;
		int                last;
		int                phase_len;

		foreach (store_mem[i]) store_mem[i] = '0;
		wr_ptr     = '0;
		slice_base = '0;
		slice_pos  = '0;
		reps_done  = '0;
		trig_cnt   = '0;
		replaying  = 1'b0;
		gain       = 32768;
		regs.trigger_interval = 20'd24000;
		regs.slice_length     = 16'd6000;
		regs.chance           = 17'd32768;
		regs.repeat_count     = 7'd4;
		regs.decay            = 16'd0;
		regs.mix              = 16'd32768;

		reg_order = '{brs_pkg::REG_TRIGGER_INTERVAL, brs_pkg::REG_SLICE_LENGTH,
			brs_pkg::REG_CHANCE, brs_pkg::REG_REPEAT_COUNT, brs_pkg::REG_DECAY,
			brs_pkg::REG_MIX};

		script = '{
			// reset settings are fully wet passthrough: out equals in
			known_row(32767, -32768, 65535, 32767, -32768, 0),
			known_row(-32768, 32767, 0, -32768, 32767, 0),
			known_row(0, 0, 16'h5555, 0, 0, 0),
			write_row(brs_pkg::REG_MIX, 0),
			known_row(-1, 1, 16'hAAAA, -1, 1, 0),
			// out-of-range and zero settings: every frame a trigger point,
			// one-frame slice, one repeat, full decay
			write_row(brs_pkg::REG_MIX, 16'hFFFF),
			write_row(brs_pkg::REG_TRIGGER_INTERVAL, 0),
			write_row(brs_pkg::REG_SLICE_LENGTH, 0),
			write_row(brs_pkg::REG_CHANCE, 17'h1FFFF),
			write_row(brs_pkg::REG_REPEAT_COUNT, 0),
			write_row(brs_pkg::REG_DECAY, 16'hFFFF),
			known_row(100, -100, 65535, 100, -100, 0),
			known_row(5, 6, 0, 100, -100, 1),
			known_row(7, 8, 0, 7, 8, 0),
			known_row(9, 10, 0, 7, 8, 1),
			write_row(brs_pkg::REG_CHANCE, 0),
			known_row(11, 12, 0, 11, 12, 0),
			write_row(brs_pkg::REG_CHANCE, 65535),
			known_row(13, 14, 65535, 13, 14, 0),
			known_row(15, 16, 65534, 15, 16, 0),
			known_row(1, 2, 0, 15, 16, 1),
			// half mix with decaying repeats
			write_row(brs_pkg::REG_MIX, 16384),
			write_row(brs_pkg::REG_DECAY, 16384),
			write_row(brs_pkg::REG_REPEAT_COUNT, 2),
			write_row(brs_pkg::REG_SLICE_LENGTH, 2),
			write_row(brs_pkg::REG_TRIGGER_INTERVAL, 4),
			write_row(brs_pkg::REG_CHANCE, 65536),
			frame_row(32767, -32768, 0),
			frame_row(-32768, 32767, 65535),
			frame_row(1000, -1000, 300),
			frame_row(-3, 3, 4000),
			frame_row(4, -4, 50000),
			frame_row(30000, -30000, 7),
			frame_row(-7, 7, 65535),
			frame_row(123, -321, 0),
			// oversized slice reaches never-written entries, then a
			// shortened slice cuts the running repeat
			write_row(brs_pkg::REG_SLICE_LENGTH, 16'hFFFF),
			write_row(brs_pkg::REG_TRIGGER_INTERVAL, 1),
			write_row(brs_pkg::REG_DECAY, 0),
			frame_row(2000, -2000, 0),
			frame_row(-501, 501, 0),
			frame_row(32767, -32768, 0),
			write_row(brs_pkg::REG_SLICE_LENGTH, 1),
			frame_row(-32768, 32767, 0),
			frame_row(77, -77, 0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (script[i].kind == STEP_WRITE) begin
				if (script[i - 1].kind != STEP_WRITE) drain();
				write_reg(script[i].index, script[i].value,
					i == SCRIPT_LEN - 1 || script[i + 1].kind != STEP_WRITE);
			end else begin
				send_frame(script[i].frame, script[i].known, script[i].want);
			end
		end

		for (int ph = 0; frames_sent < FRAME_GOAL; ph++) begin
			drain();
			mask = (ph < 2) ? 6'h3F : 6'($urandom);
			if (mask == 6'h00) mask = 6'h01;
			last = 0;
			for (int k = 0; k < 6; k++) if (mask[k]) last = k;
			for (int k = 0; k < 6; k++) begin
				if (mask[k]) begin
					if (ph == 0) begin
						setting = '1;
					end else if (ph == 1) begin
						setting = '0;
					end else begin
						case (reg_order[k])
							brs_pkg::REG_TRIGGER_INTERVAL:
								setting = ($urandom_range(0, 9) == 0) ?
									DATA_W'($urandom) :
									DATA_W'($urandom_range(0, 24));
							brs_pkg::REG_SLICE_LENGTH:
								setting = DATA_W'($urandom_range(0, 24));
							brs_pkg::REG_CHANCE:
								case ($urandom_range(0, 3))
									0: setting = '0;
									1: setting = 20'd65536;
									2: setting = 20'h1FFFF;
									default: setting = DATA_W'($urandom_range(0, 65535));
								endcase
							brs_pkg::REG_REPEAT_COUNT:
								setting = ($urandom_range(0, 9) == 0) ?
									DATA_W'($urandom_range(0, 127)) :
									DATA_W'($urandom_range(0, 6));
							default:
								case ($urandom_range(0, 3))
									0: setting = '0;
									1: setting = 20'd32768;
									2: setting = 20'h0FFFF;
									default: setting = DATA_W'($urandom_range(0, 65535));
								endcase
						endcase
					end
					write_reg(reg_order[k], setting, k == last);
				end
			end
			no_idle   = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) begin
				f.left  = pick_sample();
				f.right = pick_sample();
				case ($urandom_range(0, 7))
					0: f.draw = 16'h0000;
					1: f.draw = 16'hFFFF;
					default: f.draw = 16'($urandom);
				endcase
				send_frame(f, 1'b0, '0);
			end
		end

		drain();
		// give a stray result beat time to show up
		repeat (20) @(posedge clk);
		if (mismatches == 0 && mixes_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
